### src/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types and constants for the threshold spike extractor.
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam int MAX_SAMPLES = 4096;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 12;
    localparam int WIDTH_W  = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};
    localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(MAX_SAMPLES - 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD     = 2'd0,
        REG_CONFIRM_COUNT = 2'd1,
        REG_IGNORE_VALUE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] threshold;
        logic        [WIDTH_W-1:0]  confirm_count;
        logic signed [SAMPLE_W-1:0] ignore_value;
    } cfg_t;

endpackage

### src/ets_cfg.sv
// ----------------------------------------------------------------------------
// ets_cfg
// Configuration register bank, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module ets_cfg
    import ets_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:     cfg_next.threshold     = cfg_data;
                REG_CONFIRM_COUNT: cfg_next.confirm_count = cfg_data[WIDTH_W-1:0];
                REG_IGNORE_VALUE:  cfg_next.ignore_value  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold     <= '0;
            cfg_reg.confirm_count <= WIDTH_W'(1);
            cfg_reg.ignore_value  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/ets_core.sv
// ----------------------------------------------------------------------------
// ets_core
// Input register, run tracking logic and result register of the extractor.
// ----------------------------------------------------------------------------
module ets_core
    import ets_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic                       in_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic        [INDEX_W-1:0]  peak_position,
    output logic signed [SAMPLE_W-1:0] peak_value,
    output logic        [WIDTH_W-1:0]  spike_width
);

    // Input stage
    logic                       in_valid_reg, in_valid_next;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_last_reg;

    // Run state
    logic [INDEX_W-1:0]         sample_index_reg, sample_index_next;
    logic                       run_open_reg, run_open_next;
    logic [WIDTH_W-1:0]         run_width_reg, run_width_next;
    logic [INDEX_W-1:0]         best_index_reg, best_index_next;
    logic signed [SAMPLE_W-1:0] best_value_reg, best_value_next;

    // Result stage
    logic                       out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]         out_pos_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic [WIDTH_W-1:0]         out_width_reg;

    logic advance;
    logic accept;
    logic is_ignored;
    logic is_above;
    logic emit;

    // The held item moves on when the result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign is_ignored = (in_sample_reg == cfg.ignore_value);
    assign is_above   = (in_sample_reg > cfg.threshold) && !in_last_reg;
    assign emit = !is_ignored && !is_above && run_open_reg
                  && (run_width_reg >= cfg.confirm_count);

    always_comb
    begin
        in_valid_next = accept ? 1'b1 : (in_valid_reg && !advance);
    end

    always_comb
    begin
        sample_index_next = sample_index_reg;
        run_open_next     = run_open_reg;
        run_width_next    = run_width_reg;
        best_index_next   = best_index_reg;
        best_value_next   = best_value_reg;
        if (advance)
        begin
            if (is_ignored)
            begin
                if (run_open_reg && run_width_reg != WIDTH_MAX)
                    run_width_next = run_width_reg + WIDTH_W'(1);
            end
            else if (is_above)
            begin
                if (!run_open_reg)
                begin
                    run_open_next   = 1'b1;
                    run_width_next  = WIDTH_W'(1);
                    best_index_next = sample_index_reg;
                    best_value_next = in_sample_reg;
                end
                else
                begin
                    if (best_value_reg < in_sample_reg)
                    begin
                        best_index_next = sample_index_reg;
                        best_value_next = in_sample_reg;
                    end
                    if (run_width_reg != WIDTH_MAX)
                        run_width_next = run_width_reg + WIDTH_W'(1);
                end
            end
            else
            begin
                run_open_next   = 1'b0;
                run_width_next  = '0;
                best_index_next = '0;
                best_value_next = '0;
            end

            if (in_last_reg)
            begin
                // End of frame: the index and any open run start over.
                sample_index_next = '0;
                run_open_next     = 1'b0;
                run_width_next    = '0;
                best_index_next   = '0;
                best_value_next   = '0;
            end
            else if (sample_index_reg == INDEX_LAST)
                sample_index_next = '0;
            else
                sample_index_next = sample_index_reg + INDEX_W'(1);
        end
    end

    always_comb
    begin
        if (advance)
            out_valid_next = emit;
        else
            out_valid_next = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            sample_index_reg <= '0;
            run_open_reg     <= 1'b0;
            run_width_reg    <= '0;
            best_index_reg   <= '0;
            best_value_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            sample_index_reg <= sample_index_next;
            run_open_reg     <= run_open_next;
            run_width_reg    <= run_width_next;
            best_index_reg   <= best_index_next;
            best_value_reg   <= best_value_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sample_reg <= in_sample;
            in_last_reg   <= in_last;
        end
        if (advance && emit)
        begin
            out_pos_reg   <= best_index_reg;
            out_value_reg <= best_value_reg;
            out_width_reg <= run_width_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign peak_position = out_pos_reg;
    assign peak_value    = out_value_reg;
    assign spike_width   = out_width_reg;

    // A closed run leaves no width behind, and an open run is never empty.
    a_run_width_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !run_open_reg |-> run_width_reg == '0)
        else $error("run width left over with no open run");

    a_run_width_open: assert property (@(posedge clk) disable iff (!rst_n)
        run_open_reg |-> run_width_reg != '0)
        else $error("open run with zero width");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> sample_index_reg == '0 && !run_open_reg)
        else $error("frame state not cleared after the last sample");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && emit))
        else $error("result appeared without a closing sample");

endmodule

### src/extract_threshold_spikes.sv
// A sample accepted at s_tready shows its spike, if any, on m_tvalid once it has
// moved from the input register into the result register.
// One sample per cycle while the result register is empty or being drained.
// The result register lets the next sample in while a spike waits to be taken.
// Reset (rst_n, asynchronous, active low) clears the frame index, the run state,
// both pipeline valid flags and loads the configuration reset values.
// ----------------------------------------------------------------------------
// extract_threshold_spikes
// Threshold spike extractor: reports runs of samples above a threshold.
// ----------------------------------------------------------------------------
module extract_threshold_spikes
    import ets_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // sample stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] sample
    input  logic                 s_tlast,   // last_sample
    // spike stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // [11:0] peak_position, [27:12] peak_value,
                                            // [40:28] spike_width, [47:41] zero
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data
);

    cfg_t                       cfg;
    logic        [INDEX_W-1:0]  peak_position;
    logic signed [SAMPLE_W-1:0] peak_value;
    logic        [WIDTH_W-1:0]  spike_width;

    ets_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ets_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_sample     (s_tdata),
        .in_last       (s_tlast),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .peak_position (peak_position),
        .peak_value    (peak_value),
        .spike_width   (spike_width)
    );

    assign m_tdata = {7'd0, spike_width, peak_value, peak_position};

endmodule

### test/extract_threshold_spikes_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extract_threshold_spikes_tb
// Self-checking bench for the threshold spike extractor. A local predictor
// follows every accepted sample and queues the spikes it expects. A checker
// compares each spike transaction field by field with the oldest entry. The
// run covers directed corner cases, confirm count limits, backpressure, and
// random frames under several idling phases.
// ----------------------------------------------------------------------------
module extract_threshold_spikes_tb;
    import ets_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic        [INDEX_W-1:0]  pos;
        logic signed [SAMPLE_W-1:0] val;
        logic        [WIDTH_W-1:0]  width;
    } spike_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;   // [15:0] sample
    logic                 s_tlast   = 1'b0; // last_sample
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;          // [11:0] peak_position, [27:12] peak_value,
                                            // [40:28] spike_width, [47:41] zero
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index = REG_THRESHOLD;
    logic [SAMPLE_W-1:0]  cfg_data  = '0;

    spike_t expected_spikes[$];
    int     mismatch_count     = 0;
    int     cycle_count        = 0;
    int     sender_idle_pct    = 0;
    int     receiver_stall_pct = 0;
    int     hold_off_cycles    = 0;

    // Configuration as the block holds it.
    logic signed [SAMPLE_W-1:0] thr_q     = 16'sd0;
    logic        [WIDTH_W-1:0]  confirm_q = 13'd1;
    logic signed [SAMPLE_W-1:0] ignore_q  = 16'sh8000;

    // Predicted run state.
    logic        [INDEX_W-1:0]  frame_idx  = '0;
    logic                       run_active = 1'b0;
    logic        [WIDTH_W-1:0]  run_len    = '0;
    logic        [INDEX_W-1:0]  peak_idx   = '0;
    logic signed [SAMPLE_W-1:0] peak_val   = '0;

    logic signed [SAMPLE_W-1:0] prev_sample = '0;
    logic                       above_mode  = 1'b0;

    extract_threshold_spikes dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("extract_threshold_spikes test failed");
            $finish;
        end
    end

    // The receiver either honors a requested hold-off or stalls at random.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_spikes
        spike_t got;
        spike_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pos   = m_tdata[11:0];
            got.val   = m_tdata[27:12];
            got.width = m_tdata[40:28];
            if (expected_spikes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected spike pos=%0d value=%0d width=%0d",
                                          got.pos, got.val, got.width));
            end
            else
            begin
                want = expected_spikes.pop_front();
                if (got.pos !== want.pos)
                    report_mismatch($sformatf("peak_position %0d, expected %0d",
                                              got.pos, want.pos));
                if (got.val !== want.val)
                    report_mismatch($sformatf("peak_value %0d, expected %0d",
                                              got.val, want.val));
                if (got.width !== want.width)
                    report_mismatch($sformatf("spike_width %0d, expected %0d",
                                              got.width, want.width));
            end
        end
    end

    function automatic void clear_run();
        run_active = 1'b0;
        run_len    = '0;
        peak_idx   = '0;
        peak_val   = '0;
    endfunction

    // Advances the predicted state by one sample and queues the spike it closes.
    function automatic void predict_spike(input logic signed [SAMPLE_W-1:0] smp,
                                          input logic lst);
        spike_t sp;
        if (smp == ignore_q)
        begin
            if (run_active && run_len != WIDTH_MAX)
                run_len = run_len + 1'b1;
        end
        else if (smp > thr_q && !lst)
        begin
            if (!run_active)
            begin
                run_active = 1'b1;
                run_len    = 13'd1;
                peak_idx   = frame_idx;
                peak_val   = smp;
            end
            else
            begin
                if (peak_val < smp)
                begin
                    peak_idx = frame_idx;
                    peak_val = smp;
                end
                if (run_len != WIDTH_MAX)
                    run_len = run_len + 1'b1;
            end
        end
        else
        begin
            if (run_active && run_len >= confirm_q)
            begin
                sp.pos   = peak_idx;
                sp.val   = peak_val;
                sp.width = run_len;
                expected_spikes.push_back(sp);
            end
            clear_run();
        end
        if (lst)
        begin
            frame_idx = '0;
            clear_run();
        end
        else
        begin
            frame_idx = frame_idx + 1'b1;
        end
    endfunction

    // Leaves tvalid high after the transaction so back-to-back samples need
    // no second assignment in one time step.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        predict_spike(smp, lst);
        prev_sample = smp;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_spikes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic signed [SAMPLE_W-1:0] thr,
                                input logic [WIDTH_W-1:0] confirm,
                                input logic signed [SAMPLE_W-1:0] ign);
        cfg_reg_t            idx;
        logic [SAMPLE_W-1:0] val;
        wait_idle();
        idx = idx.first();
        repeat (idx.num())
        begin
            case (idx)
                REG_THRESHOLD:     val = thr;
                REG_CONFIRM_COUNT: val = {3'b000, confirm};
                default:           val = ign;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
        thr_q     = thr;
        confirm_q = confirm;
        ignore_q  = ign;
        @(posedge clk);
    endtask

    task automatic apply_random_config();
        int thr;
        thr = int'($urandom_range(400)) - 200;
        apply_config(16'(thr), 13'($urandom_range(5)),
                     ($urandom_range(3) == 0) ? 16'(thr - int'($urandom_range(20)))
                                              : 16'(thr + int'($urandom_range(40, 1))));
    endtask

    // Mostly runs that stay above or below the threshold, with ties, ignored
    // samples, threshold hits and some fully random noise mixed in.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int roll;
        int lo;
        int hi;
        roll = $urandom_range(99);
        if ($urandom_range(99) < 25)
            above_mode = !above_mode;
        if (roll < 8)
            return ignore_q;
        if (roll < 13)
            return 16'($urandom);
        if (roll < 20)
            return prev_sample;
        if (roll < 26)
            return thr_q;
        if (above_mode && thr_q != 16'sh7fff)
        begin
            lo = int'(thr_q) + 1;
            return 16'(lo + int'($urandom_range(32767 - lo)));
        end
        hi = int'(thr_q);
        return 16'(hi - int'($urandom_range(hi + 32768)));
    endfunction

    task automatic send_random_frames(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 1);
            for (int i = 0; i < len; i++)
                send_sample(pick_sample(), i == len - 1);
            sent += len;
        end
    endtask

    // Reset configuration: ties, ignored samples inside a run, closing at the
    // threshold, last sample above threshold, last sample equal to ignore value.
    task automatic test_reset_defaults();
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd9, 1'b1);
        send_sample(16'sd4, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(-16'sd20, 1'b1);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(-16'sd32767, 1'b1);
    endtask

    task automatic test_confirm_count();
        apply_config(-16'sd10, 13'd3, 16'sd5);
        send_sample(-16'sd9, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd10, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(-16'sd10, 1'b1);
        // A zero confirm count reports every closed run.
        apply_config(16'sd32766, 13'd0, 16'sd0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sd32766, 1'b1);
    endtask

    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        apply_config(16'sd0, 13'd1, 16'sh8000);
        hold_off_cycles = 200;
        for (int i = 0; i < 60; i++)
        begin
            send_sample(16'($urandom_range(32767, 1)), 1'b0);
            send_sample(16'(-int'($urandom_range(32767))), i == 59);
        end
        // Sender pauses here until every spike has been taken.
        wait_idle();
    endtask

    task automatic test_random_traffic();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        apply_random_config();
        send_random_frames(70);

        sender_idle_pct = 80;
        apply_config(16'sh8000, 13'd0, 16'sh7fff);
        send_random_frames(50);

        sender_idle_pct    = 0;
        receiver_stall_pct = 80;
        apply_random_config();
        send_random_frames(70);

        sender_idle_pct    = 26;
        receiver_stall_pct = 26;
        apply_config(16'sh7fff, 13'd4096, 16'sd0);
        send_random_frames(20);
        apply_random_config();
        send_random_frames(50);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_confirm_count();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("extract_threshold_spikes test passed");
        else
            $display("extract_threshold_spikes test failed");
        $finish;
    end

endmodule

### files.f
src/ets_pkg.sv
src/ets_cfg.sv
src/ets_core.sv
src/extract_threshold_spikes.sv
test/extract_threshold_spikes_tb.sv
